// ===== rtl/vpu_pkg.sv =====
// Shared types and constants for the Verlet position update core.
// Used by vpu_lane, vpu_merge and verlet_position_update_core; no dependencies.
package vpu_pkg;

  localparam int NUM_BODIES = 1024;
  localparam int BODY_W     = 10;
  localparam int IDX_W      = $clog2(NUM_BODIES);
  localparam int COORD_W    = 32;
  localparam int DT_W       = 16;
  localparam int DT2_W      = 2 * DT_W;
  localparam int VDT_W      = COORD_W + DT_W;
  localparam int ADT_W      = COORD_W + DT2_W;
  localparam int TERM_W     = COORD_W + 1;
  localparam int SUM_W      = COORD_W + 3;
  localparam int NUM_LANES  = 3;
  localparam int LATENCY    = 5;

  localparam logic signed [SUM_W-1:0] COORD_MAX =
    {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] COORD_MIN =
    {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  // rounding offsets: half of the last kept bit
  localparam logic signed [VDT_W-1:0] VDT_HALF =
    {{(VDT_W-DT_W){1'b0}}, 1'b1, {(DT_W-1){1'b0}}};
  localparam logic signed [ADT_W-1:0] ADT_HALF_STEP =
    {{(ADT_W-DT2_W){1'b0}}, 1'b1, {(DT2_W-1){1'b0}}};
  localparam logic signed [ADT_W-1:0] ADT_HALF_START =
    {{(ADT_W-DT2_W-1){1'b0}}, 1'b1, {DT2_W{1'b0}}};

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  typedef struct packed {
    logic             accept;
    logic [DT_W-1:0]  s1_dt;
    logic [DT2_W-1:0] s2_dt2;
    logic             s3_valid;
    kind_t            s3_kind;
    logic [IDX_W-1:0] s3_idx;
    logic             s4_valid;
    kind_t            s4_kind;
    logic [IDX_W-1:0] s4_idx;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord;
    logic                      sat;
  } lane_res_t;

endpackage

// ===== rtl/vpu_lane.sv =====
// One coordinate lane: products, rounding, sum and clamp, plus this
// coordinate's current and previous position memories. Depends on vpu_pkg.
module vpu_lane (
  input  logic                               clk,
  input  vpu_pkg::lane_ctrl_t                ctrl,
  input  logic signed [vpu_pkg::COORD_W-1:0] accel,
  input  logic signed [vpu_pkg::COORD_W-1:0] start_pos,
  input  logic signed [vpu_pkg::COORD_W-1:0] vel,
  output vpu_pkg::lane_res_t                 res
);

  logic signed [vpu_pkg::COORD_W-1:0] cur_mem  [vpu_pkg::NUM_BODIES];
  logic signed [vpu_pkg::COORD_W-1:0] prev_mem [vpu_pkg::NUM_BODIES];

  logic signed [vpu_pkg::COORD_W-1:0] acc1, pos1, vel1;
  logic signed [vpu_pkg::COORD_W-1:0] acc2, pos2;
  logic signed [vpu_pkg::VDT_W-1:0]   vdt2;
  logic signed [vpu_pkg::COORD_W-1:0] pos3;
  logic signed [vpu_pkg::TERM_W-1:0]  vterm3;
  logic signed [vpu_pkg::ADT_W-1:0]   adt3;
  logic signed [vpu_pkg::COORD_W-1:0] pos4;
  logic signed [vpu_pkg::TERM_W-1:0]  vterm4, aterm4;
  logic signed [vpu_pkg::COORD_W-1:0] rd_cur, rd_prev;
  logic                               fwd_hit;
  logic signed [vpu_pkg::COORD_W-1:0] fwd_cur, fwd_prev;

  logic signed [vpu_pkg::VDT_W-1:0]   vdt_next, vdt_rnd;
  logic signed [vpu_pkg::ADT_W-1:0]   adt_next, adt_rnd;
  logic signed [vpu_pkg::TERM_W-1:0]  vterm_next, aterm_next;
  logic signed [vpu_pkg::COORD_W-1:0] cur, prev, prev_new;
  logic signed [vpu_pkg::SUM_W-1:0]   sum;
  logic signed [vpu_pkg::COORD_W-1:0] coord;
  logic                               sat;

  assign vdt_next = vpu_pkg::VDT_W'(vel1)
                  * vpu_pkg::VDT_W'($signed({1'b0, ctrl.s1_dt}));
  assign vdt_rnd  = vdt2 + vpu_pkg::VDT_HALF;
  assign vterm_next = vpu_pkg::TERM_W'(vdt_rnd >>> vpu_pkg::DT_W);

  assign adt_next = vpu_pkg::ADT_W'(acc2)
                  * vpu_pkg::ADT_W'($signed({1'b0, ctrl.s2_dt2}));

  // start mode folds the factor one half into the shift
  always_comb begin
    if (ctrl.s3_kind == vpu_pkg::KIND_START) begin
      adt_rnd    = adt3 + vpu_pkg::ADT_HALF_START;
      aterm_next = vpu_pkg::TERM_W'(adt_rnd >>> (vpu_pkg::DT2_W + 1));
    end else begin
      adt_rnd    = adt3 + vpu_pkg::ADT_HALF_STEP;
      aterm_next = vpu_pkg::TERM_W'(adt_rnd >>> vpu_pkg::DT2_W);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      acc1 <= accel;
      pos1 <= start_pos;
      vel1 <= vel;
    end
    acc2   <= acc1;
    pos2   <= pos1;
    vdt2   <= vdt_next;
    pos3   <= pos2;
    vterm3 <= vterm_next;
    adt3   <= adt_next;
    pos4   <= pos3;
    vterm4 <= vterm3;
    aterm4 <= aterm_next;
  end

  // read one stage ahead; the item leaving the last stage writes on the same
  // edge, so catch its values when it names the same body
  always_ff @(posedge clk) begin
    rd_cur   <= cur_mem[ctrl.s3_idx];
    rd_prev  <= prev_mem[ctrl.s3_idx];
    fwd_hit  <= ctrl.s3_valid && ctrl.s4_valid && (ctrl.s3_idx == ctrl.s4_idx);
    fwd_cur  <= coord;
    fwd_prev <= prev_new;
  end

  always_comb begin
    cur  = fwd_hit ? fwd_cur  : rd_cur;
    prev = fwd_hit ? fwd_prev : rd_prev;
    if (ctrl.s4_kind == vpu_pkg::KIND_START) begin
      sum      = vpu_pkg::SUM_W'(pos4) + vpu_pkg::SUM_W'(vterm4)
               + vpu_pkg::SUM_W'(aterm4);
      prev_new = pos4;
    end else begin
      sum      = (vpu_pkg::SUM_W'(cur) <<< 1) - vpu_pkg::SUM_W'(prev)
               + vpu_pkg::SUM_W'(aterm4);
      prev_new = cur;
    end
    priority if (sum > vpu_pkg::COORD_MAX) begin
      coord = vpu_pkg::COORD_W'(vpu_pkg::COORD_MAX);
      sat   = 1'b1;
    end else if (sum < vpu_pkg::COORD_MIN) begin
      coord = vpu_pkg::COORD_W'(vpu_pkg::COORD_MIN);
      sat   = 1'b1;
    end else begin
      coord = vpu_pkg::COORD_W'(sum);
      sat   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s4_valid) begin
      cur_mem[ctrl.s4_idx]  <= coord;
      prev_mem[ctrl.s4_idx] <= prev_new;
    end
  end

  assign res.coord = coord;
  assign res.sat   = sat;

endmodule

// ===== rtl/vpu_merge.sv =====
// Merge stage: registers the three lane results into one result item and
// combines the clip flags. Depends on vpu_pkg.
module vpu_merge (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic [vpu_pkg::BODY_W-1:0]         in_body,
  input  vpu_pkg::lane_res_t                 lane_res [vpu_pkg::NUM_LANES],
  output logic                               done,
  output logic [vpu_pkg::BODY_W-1:0]         out_body,
  output logic signed [vpu_pkg::COORD_W-1:0] new_x,
  output logic signed [vpu_pkg::COORD_W-1:0] new_y,
  output logic signed [vpu_pkg::COORD_W-1:0] new_z,
  output logic                               saturated
);

  logic any_sat;

  always_comb begin
    any_sat = 1'b0;
    for (int i = 0; i < vpu_pkg::NUM_LANES; i++) begin
      any_sat = any_sat | lane_res[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_body  <= in_body;
    new_x     <= lane_res[0].coord;
    new_y     <= lane_res[1].coord;
    new_z     <= lane_res[2].coord;
    saturated <= any_sat;
  end

endmodule

// ===== rtl/verlet_position_update_core.sv =====
// Top level of the Verlet position update core: control pipeline, three
// coordinate lanes and the merge stage. Depends on vpu_pkg, vpu_lane, vpu_merge.
//
//   channel   handshake            payload
//   input     start / busy         kind body time_step accel_* start_* vel_*
//   result    done (one cycle)     out_body new_x new_y new_z saturated
//
// One item is accepted every cycle outside reset; each result passes in order
// through the input register, dt*dt beside v*dt, a*dt*dt beside the velocity
// rounding, the acceleration rounding beside the position read, then sum,
// clamp and position write into the result register.
// Position memories are read one stage ahead; a back-to-back item on the same
// body takes the fresh values from a bypass. busy is high only during reset.
// The receiver cannot stall, so results are never held.
module verlet_position_update_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind,
  input  logic [vpu_pkg::BODY_W-1:0]         body,
  input  logic [vpu_pkg::DT_W-1:0]           time_step,
  input  logic signed [vpu_pkg::COORD_W-1:0] accel_x,
  input  logic signed [vpu_pkg::COORD_W-1:0] accel_y,
  input  logic signed [vpu_pkg::COORD_W-1:0] accel_z,
  input  logic signed [vpu_pkg::COORD_W-1:0] start_x,
  input  logic signed [vpu_pkg::COORD_W-1:0] start_y,
  input  logic signed [vpu_pkg::COORD_W-1:0] start_z,
  input  logic signed [vpu_pkg::COORD_W-1:0] vel_x,
  input  logic signed [vpu_pkg::COORD_W-1:0] vel_y,
  input  logic signed [vpu_pkg::COORD_W-1:0] vel_z,
  output logic                               done,
  output logic [vpu_pkg::BODY_W-1:0]         out_body,
  output logic signed [vpu_pkg::COORD_W-1:0] new_x,
  output logic signed [vpu_pkg::COORD_W-1:0] new_y,
  output logic signed [vpu_pkg::COORD_W-1:0] new_z,
  output logic                               saturated
);

  logic                      accept;
  logic                      p1_valid, p2_valid, p3_valid, p4_valid;
  vpu_pkg::kind_t            p1_kind, p2_kind, p3_kind, p4_kind;
  logic [vpu_pkg::BODY_W-1:0] p1_body, p2_body, p3_body, p4_body;
  logic [vpu_pkg::DT_W-1:0]  p1_dt;
  logic [vpu_pkg::DT2_W-1:0] p2_dt2;
  vpu_pkg::lane_ctrl_t       ctrl;
  vpu_pkg::lane_res_t        lane_res [vpu_pkg::NUM_LANES];

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_kind <= vpu_pkg::kind_t'(kind);
      p1_body <= body;
      p1_dt   <= time_step;
    end
    p2_kind <= p1_kind;
    p2_body <= p1_body;
    p2_dt2  <= vpu_pkg::DT2_W'(p1_dt) * vpu_pkg::DT2_W'(p1_dt);
    p3_kind <= p2_kind;
    p3_body <= p2_body;
    p4_kind <= p3_kind;
    p4_body <= p3_body;
  end

  // entry index is the body modulo the (power of two) body count
  always_comb begin
    ctrl.accept   = accept;
    ctrl.s1_dt    = p1_dt;
    ctrl.s2_dt2   = p2_dt2;
    ctrl.s3_valid = p3_valid;
    ctrl.s3_kind  = p3_kind;
    ctrl.s3_idx   = p3_body[vpu_pkg::IDX_W-1:0];
    ctrl.s4_valid = p4_valid;
    ctrl.s4_kind  = p4_kind;
    ctrl.s4_idx   = p4_body[vpu_pkg::IDX_W-1:0];
  end

  vpu_lane u_lane_x (
    .clk       (clk),
    .ctrl      (ctrl),
    .accel     (accel_x),
    .start_pos (start_x),
    .vel       (vel_x),
    .res       (lane_res[0])
  );

  vpu_lane u_lane_y (
    .clk       (clk),
    .ctrl      (ctrl),
    .accel     (accel_y),
    .start_pos (start_y),
    .vel       (vel_y),
    .res       (lane_res[1])
  );

  vpu_lane u_lane_z (
    .clk       (clk),
    .ctrl      (ctrl),
    .accel     (accel_z),
    .start_pos (start_z),
    .vel       (vel_z),
    .res       (lane_res[2])
  );

  vpu_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p4_valid),
    .in_body   (p4_body),
    .lane_res  (lane_res),
    .done      (done),
    .out_body  (out_body),
    .new_x     (new_x),
    .new_y     (new_y),
    .new_z     (new_z),
    .saturated (saturated)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("accepted item produced no result");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, vpu_pkg::LATENCY))
    else $error("result without a matching item");

  a_body: assert property (@(posedge clk) disable iff (rst)
    done |-> out_body == $past(body, vpu_pkg::LATENCY))
    else $error("result carries the wrong body index");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    !p4_valid |=> !done)
    else $error("result strobe without a finished item");

endmodule

// ===== test/verlet_position_update_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for verlet_position_update_core: predicts every body update from
// the accepted items and compares each result field by field. Depends on vpu_pkg.
module verlet_position_update_checker
  import vpu_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      kind,
  input  logic [BODY_W-1:0]         body,
  input  logic [DT_W-1:0]           time_step,
  input  logic signed [COORD_W-1:0] accel_x,
  input  logic signed [COORD_W-1:0] accel_y,
  input  logic signed [COORD_W-1:0] accel_z,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] start_z,
  input  logic signed [COORD_W-1:0] vel_x,
  input  logic signed [COORD_W-1:0] vel_y,
  input  logic signed [COORD_W-1:0] vel_z,
  input  logic                      done,
  input  logic [BODY_W-1:0]         out_body,
  input  logic signed [COORD_W-1:0] new_x,
  input  logic signed [COORD_W-1:0] new_y,
  input  logic signed [COORD_W-1:0] new_z,
  input  logic                      saturated,
  output int                        fail_count,
  output int                        pending_items
);

  localparam longint POS_HI = 64'sd2147483647;
  localparam longint POS_LO = -64'sd2147483648;

  typedef struct packed {
    logic [BODY_W-1:0]  body;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               sat;
  } update_t;

  longint  cur_pos  [NUM_BODIES][3];
  longint  prev_pos [NUM_BODIES][3];
  update_t positions_due [$];
  int      errors = 0;

  // round to nearest, ties toward plus infinity
  function automatic longint round_half_up(longint x, int unsigned s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Advance one body and return the position it reports.
  function automatic update_t integrate_body(kind_t k, logic [BODY_W-1:0] b,
                                             logic [DT_W-1:0] dt_in,
                                             logic [3*COORD_W-1:0] acc_v,
                                             logic [3*COORD_W-1:0] pos_v,
                                             logic [3*COORD_W-1:0] vel_v);
    update_t            upd;
    int                 idx;
    longint             dt;
    longint             dt2;
    longint             acc;
    longint             x0;
    longint             vel;
    longint             raw;
    longint             res;
    logic [COORD_W-1:0] coord [3];
    idx = int'(b) % NUM_BODIES;
    dt  = longint'(dt_in);
    dt2 = dt * dt;
    upd.sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      acc = longint'(signed'(acc_v[c*COORD_W +: COORD_W]));
      if (k == KIND_START) begin
        x0  = longint'(signed'(pos_v[c*COORD_W +: COORD_W]));
        vel = longint'(signed'(vel_v[c*COORD_W +: COORD_W]));
        // the extra bit of shift on the acceleration term is the factor 1/2
        raw = x0 + round_half_up(vel * dt, DT_W) + round_half_up(acc * dt2, 2*DT_W + 1);
        prev_pos[idx][c] = x0;
      end else begin
        raw = 2 * cur_pos[idx][c] - prev_pos[idx][c] + round_half_up(acc * dt2, 2*DT_W);
        prev_pos[idx][c] = cur_pos[idx][c];
      end
      if (raw > POS_HI) begin
        res = POS_HI;
        upd.sat = 1'b1;
      end else if (raw < POS_LO) begin
        res = POS_LO;
        upd.sat = 1'b1;
      end else begin
        res = raw;
      end
      cur_pos[idx][c] = res;
      coord[c] = res[COORD_W-1:0];
    end
    upd.body = b;
    upd.x    = coord[0];
    upd.y    = coord[1];
    upd.z    = coord[2];
    return upd;
  endfunction

  task automatic check_field(string name, logic [BODY_W-1:0] b,
                             logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: body %0d %s mismatch: expected %h actual %h",
               $time, b, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    update_t want;
    if (!rst) begin
      if (done) begin
        if (positions_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none actual body %0d %h %h %h sat %b",
                   $time, out_body, new_x, new_y, new_z, saturated);
        end else begin
          want = positions_due.pop_front();
          check_field("out_body", want.body, COORD_W'(want.body), COORD_W'(out_body));
          check_field("new_x", want.body, want.x, new_x);
          check_field("new_y", want.body, want.y, new_y);
          check_field("new_z", want.body, want.z, new_z);
          check_field("saturated", want.body, COORD_W'(want.sat), COORD_W'(saturated));
        end
      end
      if (start && !busy)
        positions_due.push_back(integrate_body(kind_t'(kind), body, time_step,
                                               {accel_z, accel_y, accel_x},
                                               {start_z, start_y, start_x},
                                               {vel_z, vel_y, vel_x}));
      pending_items <= positions_due.size();
      fail_count    <= errors;
    end
  end

endmodule

// ===== test/tb_verlet_position_update_core.sv =====
`timescale 1ns / 1ps
// Testbench top for verlet_position_update_core: clock, reset, directed and
// random body items, verdict. Depends on vpu_pkg and verlet_position_update_checker.
module tb_verlet_position_update_core;
  import vpu_pkg::*;

  localparam int NUM_RANDOM  = 1350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 6;

  typedef struct packed {
    logic                 k;
    logic [BODY_W-1:0]    body;
    logic [DT_W-1:0]      dt;
    logic [3*COORD_W-1:0] acc;
    logic [3*COORD_W-1:0] pos;
    logic [3*COORD_W-1:0] vel;
  } body_item_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      kind;
  logic [BODY_W-1:0]         body;
  logic [DT_W-1:0]           time_step;
  logic signed [COORD_W-1:0] accel_x, accel_y, accel_z;
  logic signed [COORD_W-1:0] start_x, start_y, start_z;
  logic signed [COORD_W-1:0] vel_x, vel_y, vel_z;
  logic                      done;
  logic [BODY_W-1:0]         out_body;
  logic signed [COORD_W-1:0] new_x, new_y, new_z;
  logic                      saturated;
  int                        fail_count;
  int                        pending_items;
  int                        cycle_count = 0;
  bit                        started [NUM_BODIES];

  always #5 clk = ~clk;

  verlet_position_update_core u_dut (
    .clk, .rst, .start, .busy, .kind, .body, .time_step,
    .accel_x, .accel_y, .accel_z, .start_x, .start_y, .start_z,
    .vel_x, .vel_y, .vel_z,
    .done, .out_body, .new_x, .new_y, .new_z, .saturated
  );

  verlet_position_update_checker u_checker (
    .clk, .rst, .start, .busy, .kind, .body, .time_step,
    .accel_x, .accel_y, .accel_z, .start_x, .start_y, .start_z,
    .vel_x, .vel_y, .vel_z,
    .done, .out_body, .new_x, .new_y, .new_z, .saturated,
    .fail_count, .pending_items
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic body_item_t uniform_item(kind_t k, int b, int dt,
                                              logic [COORD_W-1:0] a,
                                              logic [COORD_W-1:0] p,
                                              logic [COORD_W-1:0] v);
    return '{k: k, body: BODY_W'(b), dt: DT_W'(dt),
             acc: {3{a}}, pos: {3{p}}, vel: {3{v}}};
  endfunction

  function automatic logic [COORD_W-1:0] draw_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return COORD_W'(int'($urandom_range(0, 2**21)) - 2**20);
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return '0;
          3: return '1;
          default: return 32'd1;
        endcase
      end
      default: return COORD_W'(int'($urandom_range(0, 2**25)) - 2**24);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] draw_dt();
    case ($urandom_range(0, 3))
      0: return DT_W'($urandom_range(0, 65535));
      1: return DT_W'($urandom_range(0, 16'h0400));
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return 16'h8000;
          default: return 16'd1;
        endcase
      end
      default: return DT_W'($urandom_range(0, 16'h2000));
    endcase
  endfunction

  task automatic send_item(input body_item_t it);
    kind      <= it.k;
    body      <= it.body;
    time_step <= it.dt;
    accel_x   <= it.acc[0*COORD_W +: COORD_W];
    accel_y   <= it.acc[1*COORD_W +: COORD_W];
    accel_z   <= it.acc[2*COORD_W +: COORD_W];
    start_x   <= it.pos[0*COORD_W +: COORD_W];
    start_y   <= it.pos[1*COORD_W +: COORD_W];
    start_z   <= it.pos[2*COORD_W +: COORD_W];
    vel_x     <= it.vel[0*COORD_W +: COORD_W];
    vel_y     <= it.vel[1*COORD_W +: COORD_W];
    vel_z     <= it.vel[2*COORD_W +: COORD_W];
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    if (it.k == KIND_START)
      started[it.body] = 1'b1;
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // hold the next item until every update in flight has come back
  task automatic drain_updates();
    start <= 1'b0;
    @(posedge clk);
    while (pending_items != 0) @(posedge clk);
  endtask

  initial begin
    body_item_t it;
    int         pool [POOL_SIZE];
    int         last_body;
    int         b;
    bit         idle_on;

    rst       <= 1'b1;
    start     <= 1'b0;
    kind      <= KIND_START;
    body      <= '0;
    time_step <= '0;
    accel_x   <= '0;
    accel_y   <= '0;
    accel_z   <= '0;
    start_x   <= '0;
    start_y   <= '0;
    start_z   <= '0;
    vel_x     <= '0;
    vel_y     <= '0;
    vel_z     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // zero step, saturation at both ends, rounding ties, back-to-back steps
    send_item(uniform_item(KIND_START, 0, 0, '0, '0, '0));
    send_item(uniform_item(KIND_START, 1023, 16'hffff, 32'h7fff_ffff, 32'h7fff_ffff,
                           32'h7fff_ffff));
    send_item(uniform_item(KIND_START, 1, 16'hffff, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000));
    send_item(uniform_item(KIND_STEP, 1023, 16'hffff, 32'h7fff_ffff, '0, '0));
    send_item(uniform_item(KIND_STEP, 1, 16'hffff, 32'h8000_0000, '0, '0));
    send_item(uniform_item(KIND_START, 2, 16'h8000, 32'd4, '0, 32'd1));
    send_item(uniform_item(KIND_START, 3, 16'h8000, -32'sd4, '0, -32'sd1));
    send_item(uniform_item(KIND_STEP, 2, 16'h8000, 32'd2, '0, '0));
    send_item(uniform_item(KIND_STEP, 3, 16'h8000, -32'sd2, '0, '0));
    send_item(uniform_item(KIND_START, 5, 16'h1000, 32'h0001_0000, 32'h0001_0000,
                           32'h0002_0000));
    repeat (4) send_item(uniform_item(KIND_STEP, 5, 16'h1000, 32'hfff8_0000, '0, '0));
    send_item(uniform_item(KIND_STEP, 5, 0, 32'h7fff_ffff, '0, '0));
    send_item(uniform_item(KIND_STEP, 0, 16'hffff, '0, '0, '0));
    send_item(uniform_item(KIND_START, 512, 0, '0, 32'h7fff_ffff, '0));
    send_item(uniform_item(KIND_STEP, 512, 0, '0, '0, '0));
    send_item(uniform_item(KIND_START, 512, 0, 32'h7fff_ffff, 32'h8000_0000,
                           32'h7fff_ffff));
    send_item(uniform_item(KIND_STEP, 512, 16'hffff, 32'h8000_0000, '0, '0));
    drain_updates();

    foreach (pool[i]) pool[i] = $urandom_range(0, NUM_BODIES - 1);
    last_body = pool[0];
    idle_on   = 1'b0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 64 == 0)
        idle_on = ($urandom_range(0, 9) < 7);
      if (n % 400 == 399)
        drain_updates();
      // favor a few bodies so that dependent updates follow closely
      case ($urandom_range(0, 9))
        0, 1, 2: b = last_body;
        3, 4, 5, 6: b = pool[$urandom_range(0, POOL_SIZE - 1)];
        default: b = $urandom_range(0, NUM_BODIES - 1);
      endcase
      it.body = BODY_W'(b);
      it.k    = (!started[b] || $urandom_range(0, 99) < 12) ? KIND_START : KIND_STEP;
      it.dt   = draw_dt();
      it.acc  = {draw_coord(), draw_coord(), draw_coord()};
      it.pos  = {draw_coord(), draw_coord(), draw_coord()};
      it.vel  = {draw_coord(), draw_coord(), draw_coord()};
      send_item(it);
      last_body = b;
      hold_off(idle_on ? $urandom_range(0, 11) : 0);
    end

    drain_updates();
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0 && pending_items == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
